// ===== sv/mlk_pkg.sv =====
package mlk_pkg;

    localparam int DOT_W  = 24;
    localparam int DUR_W  = 27;
    localparam int CHAR_W = 8;

    localparam logic [DOT_W-1:0]  DOT_TICKS_RESET = 24'd250000;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam int                CODE_COUNT      = 36;
    localparam logic [5:0]        DIGIT_BASE      = 6'd26;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LETTER,
        KIND_SPACE
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAP,
        ST_ELEM,
        ST_SPACE
    } t_state;

    typedef enum logic [1:0] {
        UNITS_1,
        UNITS_3,
        UNITS_7
    } t_units;

    typedef struct packed {
        logic   led_on;
        t_units units;
        logic   last;
    } t_interval;

    // pattern msb-first of count elements, 1 = dash
    typedef struct packed {
        logic [4:0] pattern;
        logic [2:0] count;
    } t_code;

    localparam logic [7:0] CODE_TABLE [CODE_COUNT] = '{
        8'h0a, 8'h44, 8'h54, 8'h23, 8'h01, 8'h14, 8'h33, 8'h04, 8'h02, 8'h3c,
        8'h2b, 8'h24, 8'h1a, 8'h12, 8'h3b, 8'h34, 8'h6c, 8'h13, 8'h03, 8'h09,
        8'h0b, 8'h0c, 8'h1b, 8'h4c, 8'h5c, 8'h64,
        8'hfd, 8'h7d, 8'h3d, 8'h1d, 8'h0d, 8'h05, 8'h85, 8'hc5, 8'he5, 8'hf5
    };

    function automatic t_code lookup(input logic [CHAR_W-1:0] ch);
        logic [5:0] idx;
        logic       hit;
        t_code      c;
        idx = '0;
        hit = 1'b0;
        case (ch) inside
            [8'h61:8'h7a]: begin
                hit = 1'b1;
                idx = 6'(ch - 8'h61);
            end
            [8'h30:8'h39]: begin
                hit = 1'b1;
                idx = 6'(ch - 8'h30) + DIGIT_BASE;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        c = hit ? t_code'(CODE_TABLE[idx]) : t_code'(8'h00);
        return c;
    endfunction

endpackage

// ===== sv/mlk_dur.sv =====
module mlk_dur (
    input  logic [mlk_pkg::DOT_W-1:0] i_dot_ticks,
    input  mlk_pkg::t_units           i_units,
    output logic [mlk_pkg::DUR_W-1:0] o_duration
);

    logic [mlk_pkg::DUR_W-1:0] dot;
    logic [mlk_pkg::DUR_W-1:0] opa;
    logic                      sub;

    assign dot = mlk_pkg::DUR_W'(i_dot_ticks);

    always_comb begin
        case (i_units)
            mlk_pkg::UNITS_1: begin
                opa = '0;
                sub = 1'b0;
            end
            mlk_pkg::UNITS_3: begin
                opa = dot << 1;
                sub = 1'b0;
            end
            mlk_pkg::UNITS_7: begin
                opa = dot << 3;
                sub = 1'b1;
            end
            default: begin
                opa = '0;
                sub = 1'b0;
            end
        endcase
    end

    // single shared add/subtract
    assign o_duration = sub ? (opa - dot) : (opa + dot);

endmodule

// ===== sv/mlk_seq.sv =====
module mlk_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [mlk_pkg::CHAR_W-1:0] i_character,
    input  logic                       i_end_of_text,
    input  logic                       i_advance,
    output logic                       o_busy,
    output mlk_pkg::t_interval         o_interval
);

    mlk_pkg::t_state r_state, n_state;
    mlk_pkg::t_kind  r_prev_kind, n_prev_kind;
    logic [2:0]      r_count, n_count;
    logic [4:0]      r_pattern, n_pattern;
    logic            r_gap7, n_gap7;

    mlk_pkg::t_code  ld_code;
    logic            is_space;
    logic [2:0]      elem_idx;

    assign ld_code  = mlk_pkg::lookup(i_character);
    assign is_space = (i_character == mlk_pkg::CHAR_SPACE);
    assign elem_idx = r_count - 3'd1;

    always_comb begin
        n_state     = r_state;
        n_prev_kind = r_prev_kind;
        n_count     = r_count;
        n_pattern   = r_pattern;
        n_gap7      = r_gap7;
        case (r_state)
            mlk_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_pattern = ld_code.pattern;
                    n_count   = ld_code.count;
                    n_gap7    = (r_prev_kind == mlk_pkg::KIND_SPACE);
                    if (i_end_of_text) begin
                        n_prev_kind = mlk_pkg::KIND_NONE;
                    end else if (is_space) begin
                        n_prev_kind = mlk_pkg::KIND_SPACE;
                    end else begin
                        n_prev_kind = mlk_pkg::KIND_LETTER;
                    end
                    if (r_prev_kind == mlk_pkg::KIND_SPACE ||
                        (r_prev_kind == mlk_pkg::KIND_LETTER && !is_space)) begin
                        n_state = mlk_pkg::ST_GAP;
                    end else if (ld_code.count != 3'd0) begin
                        n_state = mlk_pkg::ST_ELEM;
                    end
                end
            end
            mlk_pkg::ST_GAP: begin
                if (i_advance) begin
                    n_state = (r_count != 3'd0) ? mlk_pkg::ST_ELEM : mlk_pkg::ST_IDLE;
                end
            end
            mlk_pkg::ST_ELEM: begin
                if (i_advance) begin
                    n_count = r_count - 3'd1;
                    n_state = (r_count > 3'd1) ? mlk_pkg::ST_SPACE : mlk_pkg::ST_IDLE;
                end
            end
            mlk_pkg::ST_SPACE: begin
                if (i_advance) begin
                    n_state = mlk_pkg::ST_ELEM;
                end
            end
            default: begin
                n_state = mlk_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy            = (r_state != mlk_pkg::ST_IDLE);
        o_interval.led_on = 1'b0;
        o_interval.units  = mlk_pkg::UNITS_1;
        o_interval.last   = 1'b0;
        case (r_state)
            mlk_pkg::ST_GAP: begin
                o_interval.units = r_gap7 ? mlk_pkg::UNITS_7 : mlk_pkg::UNITS_3;
                o_interval.last  = (r_count == 3'd0);
            end
            mlk_pkg::ST_ELEM: begin
                o_interval.led_on = 1'b1;
                o_interval.units  = r_pattern[elem_idx] ? mlk_pkg::UNITS_3
                                                        : mlk_pkg::UNITS_1;
                o_interval.last   = (r_count == 3'd1);
            end
            mlk_pkg::ST_SPACE: begin
                o_interval.units = mlk_pkg::UNITS_1;
            end
            default: begin
                o_interval.led_on = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlk_pkg::ST_IDLE;
            r_prev_kind <= mlk_pkg::KIND_NONE;
        end else begin
            r_state     <= n_state;
            r_prev_kind <= n_prev_kind;
        end
        r_count   <= n_count;
        r_pattern <= n_pattern;
        r_gap7    <= n_gap7;
    end

endmodule

// ===== sv/morse_code_led_keyer.sv =====
// the first interval of an item is set up in the sequencer registers, then held in the output register
// throughput: one interval per cycle from the sequencer and shared add/sub unit
// while i_stall does not hold the output; an item gives a gap, elements and spaces
// a new item is taken once the sequencer is idle, even with a result still waiting
// reset (synchronous, active low) clears the sequencer state, the output valid flag and
// the word-gap history, and sets dot_ticks to 250000
module morse_code_led_keyer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mlk_pkg::CHAR_W-1:0]   i_character,
    input  logic                         i_end_of_text,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_led_on,
    output logic [mlk_pkg::DUR_W-1:0]    o_duration,
    output logic                         o_last_of_run,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mlk_pkg::DOT_W-1:0]    i_dot_ticks
);

    logic [mlk_pkg::DOT_W-1:0] r_dot_ticks;
    logic                      r_out_valid;
    logic                      r_led_on;
    logic [mlk_pkg::DUR_W-1:0] r_duration;
    logic                      r_last;

    logic                      busy;
    logic                      advance;
    mlk_pkg::t_interval        interval;
    logic [mlk_pkg::DUR_W-1:0] duration;

    assign advance = busy && (!r_out_valid || !i_stall);

    mlk_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_character   (i_character),
        .i_end_of_text (i_end_of_text),
        .i_advance     (advance),
        .o_busy        (busy),
        .o_interval    (interval)
    );

    mlk_dur u_dur (
        .i_dot_ticks (r_dot_ticks),
        .i_units     (interval.units),
        .o_duration  (duration)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks <= mlk_pkg::DOT_TICKS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dot_ticks <= i_dot_ticks;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_led_on   <= interval.led_on;
            r_duration <= duration;
            r_last     <= interval.last;
        end
    end

    assign o_stall       = busy;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_led_on      = r_led_on;
    assign o_duration    = r_duration;
    assign o_last_of_run = r_last;

endmodule

// ===== sv/mlk_checker.sv =====
module mlk_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_led_on,
    input logic [mlk_pkg::DUR_W-1:0]  o_duration,
    input logic                       o_last_of_run
);

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_led_on) && $stable(o_duration)
                               && $stable(o_last_of_run))
        else $error("stalled output item changed");

    // a run streams without bubbles until its last interval
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid)
        else $error("gap inside a run of intervals");

    // a lit element that is not last is followed by a dark gap
    a_dark_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_led_on && !o_last_of_run |=> o_valid && !o_led_on)
        else $error("element not followed by a dark gap");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

endmodule

bind morse_code_led_keyer mlk_checker u_mlk_checker (.*);
